>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the stack machine execute block.
// Depends on nothing; the macros expand to nothing in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define SMX_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Next-cycle implication, checked outside reset.
`define SMX_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define SMX_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SMX_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> rtl/core/smx_pkg.sv
// Package for the stack machine execute block: opcodes, error codes,
// sequencer states and the divider request/response structs. No dependencies.
`timescale 1ns / 1ps

package smx_pkg;

    typedef enum logic [3:0] {
        OP_HALT = 4'd0,
        OP_PUSH = 4'd1,
        OP_LOAD = 4'd2,
        OP_POP  = 4'd3,
        OP_ADD  = 4'd4,
        OP_SUB  = 4'd5,
        OP_MUL  = 4'd6,
        OP_DIV  = 4'd7,
        OP_SET  = 4'd8
    } t_opcode;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_OVERFLOW  = 3'd1,
        ERR_UNDERFLOW = 3'd2,
        ERR_DIV_ZERO  = 3'd3,
        ERR_BAD_REG   = 3'd4,
        ERR_BAD_OP    = 3'd5
    } t_err;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_EXEC = 7'b0000010,
        S_RD   = 7'b0000100,
        S_RD2  = 7'b0001000,
        S_MUL  = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    // Instruction word lengths
    localparam logic [31:0] LEN_ONE   = 32'd1;
    localparam logic [31:0] LEN_TWO   = 32'd2;
    localparam logic [31:0] LEN_THREE = 32'd3;

    localparam int DIV_STEPS = 32;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } t_div_rsp;

endpackage

>>> rtl/core/smx_stack_ram.sv
// Stack memory: one write port, one read port with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module smx_stack_ram #(
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [31:0]              i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [31:0]              o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/smx_regfile.sv
// General register file with per-entry valid bits so entries read as zero
// after reset. Registered read data. Depends on nothing.
`timescale 1ns / 1ps

module smx_regfile #(
    parameter int NUM_REGS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_we,
    input  logic [$clog2(NUM_REGS)-1:0] i_waddr,
    input  logic [31:0]                 i_wdata,
    input  logic [$clog2(NUM_REGS)-1:0] i_raddr,
    output logic [31:0]                 o_rdata
);

    logic [31:0]         r_mem [NUM_REGS];
    logic [NUM_REGS-1:0] r_valid;
    logic [31:0]         r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_valid[i_raddr] ? r_mem[i_raddr] : 32'd0;
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/smx_div.sv
// Signed 32-bit divider, truncating toward zero, one quotient bit a cycle.
// Depends on smx_pkg for the request/response structs.
`timescale 1ns / 1ps

module smx_div
    import smx_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_dvs;
    logic        r_neg;
    logic [31:0] r_q;

    logic [31:0] w_dvd_abs;
    logic [31:0] w_dvs_abs;
    logic [32:0] w_shift;
    logic [32:0] w_diff;
    logic        w_ge;

    // Magnitudes; the most negative value maps to 2^31, which fits unsigned.
    assign w_dvd_abs = i_req.dividend[31] ? (32'd0 - i_req.dividend) : i_req.dividend;
    assign w_dvs_abs = i_req.divisor[31]  ? (32'd0 - i_req.divisor)  : i_req.divisor;

    assign w_shift = {r_rem, r_quo[31]};
    assign w_ge    = (w_shift >= {1'b0, r_dvs});
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(DIV_STEPS);
            end else if (r_busy) begin
                if (r_cnt != 6'd0) begin
                    r_cnt <= r_cnt - 6'd1;
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= 32'd0;
            r_quo <= w_dvd_abs;
            r_dvs <= w_dvs_abs;
            r_neg <= i_req.dividend[31] ^ i_req.divisor[31];
        end else if (r_busy) begin
            if (r_cnt != 6'd0) begin
                r_rem <= w_ge ? w_diff[31:0] : w_shift[31:0];
                r_quo <= {r_quo[30:0], w_ge};
            end else begin
                // Apply sign; min-int over minus one wraps back to min-int
                r_q <= r_neg ? (32'd0 - r_quo) : r_quo;
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

endmodule

>>> rtl/core/stack_machine_execute_core.sv
// Top level of the stack machine execute block: instruction sequencer,
// stack pointer, instruction pointer and output register.
// Depends on smx_pkg, smx_stack_ram, smx_regfile, smx_div, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Input channel: i_in_valid / o_in_stall carry one decoded instruction
// (i_cmd, i_operand_a, i_operand_b). A transfer happens on a rising edge
// with valid high and stall low. Output channel: o_out_valid / i_out_stall
// carry one result (value, error code, halted flag, next instruction
// pointer) for every instruction taken.
// One instruction is in flight at a time. From the input transfer to the
// result on the output, halt, push, set, errors and a stopped block pass
// through the execute and output states; load and pop add a read state; add
// and sub add two reads through the single stack read port, mul a read and
// the multiply register, div a read and the one-bit-per-cycle divider.
// The next instruction can be taken in the cycle after the result is handed
// to the output register, not before the last one has got there.
// While the receiver stalls, the finished result waits in the output
// register and one more instruction can still be taken and executed; it
// then holds until the output register drains.
// Reset: empty stack (top index minus one), instruction pointer zero,
// registers read as zero, block running. Stack contents are undefined until
// pushed. A halt or any error stops the block until the next reset.

module stack_machine_execute_core
    import smx_pkg::*;
#(
    parameter int STACK_DEPTH = 256,
    parameter int NUM_REGS    = 8,
    parameter int IP_INDEX    = 6,
    parameter int SP_INDEX    = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [3:0]         i_cmd,
    input  logic signed [31:0] i_operand_a,
    input  logic signed [31:0] i_operand_b,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_result_value,
    output logic [2:0]         o_error_code,
    output logic               o_halted,
    output logic signed [31:0] o_next_ip
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int RW = $clog2(NUM_REGS);
    localparam logic signed [32:0] K_TOP  = 33'(STACK_DEPTH - 1);
    localparam logic signed [32:0] K_NREG = 33'(NUM_REGS);
    localparam logic signed [32:0] K_IP   = 33'(IP_INDEX);
    localparam logic signed [32:0] K_SP   = 33'(SP_INDEX);

    t_state      r_state, n_state;
    logic [3:0]  r_cmd, n_cmd;
    logic [31:0] r_a, n_a;
    logic [31:0] r_b, n_b;
    logic [31:0] r_sp, n_sp;
    logic [31:0] r_ip, n_ip;
    logic        r_running, n_running;
    logic [31:0] r_res, n_res;
    t_err        r_err, n_err;
    logic        r_halt, n_halt;
    logic [31:0] r_nip, n_nip;
    logic [31:0] r_top, n_top;
    logic        r_ovalid, n_ovalid;
    logic [31:0] r_ores, n_ores;
    t_err        r_oerr, n_oerr;
    logic        r_ohalt, n_ohalt;
    logic [31:0] r_onip, n_onip;

    logic signed [32:0] w_sp_x;
    logic signed [32:0] w_nsp;
    logic signed [32:0] w_a_x;
    logic [31:0]        w_spm1;
    logic               w_a_bad;
    t_err               w_err;
    logic [31:0]        w_len;
    logic [31:0]        w_load_val;

    logic          w_stk_we;
    logic [AW-1:0] w_stk_waddr;
    logic [31:0]   w_stk_wdata;
    logic [AW-1:0] w_stk_raddr;
    logic [31:0]   w_stk_q;
    logic          w_rf_we;
    logic [31:0]   w_rf_q;
    t_div_req      w_div_req;
    t_div_rsp      w_div_rsp;

    smx_stack_ram #(
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_stk_we),
        .i_waddr (w_stk_waddr),
        .i_wdata (w_stk_wdata),
        .i_raddr (w_stk_raddr),
        .o_rdata (w_stk_q)
    );

    smx_regfile #(
        .NUM_REGS (NUM_REGS)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_rf_we),
        .i_waddr (r_a[RW-1:0]),
        .i_wdata (r_b),
        .i_raddr (r_a[RW-1:0]),
        .o_rdata (w_rf_q)
    );

    smx_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign w_sp_x  = {r_sp[31], r_sp};
    assign w_nsp   = w_sp_x + 33'sd1;
    assign w_a_x   = {r_a[31], r_a};
    assign w_spm1  = r_sp - 32'd1;
    assign w_a_bad = (w_a_x < 33'sd0) || (w_a_x >= K_NREG);

    // Instruction pointer and stack pointer alias two register indexes
    assign w_load_val = (w_a_x == K_IP) ? (r_ip + 32'd1)
                      : (w_a_x == K_SP) ? w_nsp[31:0]
                      : w_rf_q;

    // Error and word length depend only on the opcode, operands and pointers
    always_comb begin
        w_err = ERR_NONE;
        w_len = LEN_ONE;
        case (r_cmd)
            OP_HALT: begin
                w_len = LEN_ONE;
            end
            OP_PUSH, OP_LOAD: begin
                w_len = LEN_TWO;
                if (w_nsp < 33'sd0) begin
                    w_err = ERR_UNDERFLOW;
                end else if (w_nsp >= K_TOP) begin
                    w_err = ERR_OVERFLOW;
                end else if (r_cmd == OP_LOAD && w_a_bad) begin
                    w_err = ERR_BAD_REG;
                end
            end
            OP_POP, OP_MUL, OP_DIV: begin
                w_len = (r_cmd == OP_POP) ? LEN_ONE : LEN_TWO;
                if (w_sp_x < 33'sd0) begin
                    w_err = ERR_UNDERFLOW;
                end else if (w_sp_x > K_TOP) begin
                    w_err = ERR_OVERFLOW;
                end else if (r_cmd == OP_DIV && r_a == 32'd0) begin
                    w_err = ERR_DIV_ZERO;
                end
            end
            OP_ADD, OP_SUB: begin
                w_len = LEN_ONE;
                if (w_sp_x < 33'sd1) begin
                    w_err = ERR_UNDERFLOW;
                end else if (w_sp_x > K_TOP) begin
                    w_err = ERR_OVERFLOW;
                end
            end
            OP_SET: begin
                w_len = LEN_THREE;
                if (w_a_bad) begin
                    w_err = ERR_BAD_REG;
                end
            end
            default: begin
                w_err = ERR_BAD_OP;
            end
        endcase
    end

    // Sequencer. Every stack write lands before the next instruction issues
    // its first read, so the memory needs no forwarding.
    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_a       = r_a;
        n_b       = r_b;
        n_sp      = r_sp;
        n_ip      = r_ip;
        n_running = r_running;
        n_res     = r_res;
        n_err     = r_err;
        n_halt    = r_halt;
        n_nip     = r_nip;
        n_top     = r_top;
        n_ovalid  = r_ovalid;
        n_ores    = r_ores;
        n_oerr    = r_oerr;
        n_ohalt   = r_ohalt;
        n_onip    = r_onip;

        w_stk_we    = 1'b0;
        w_stk_waddr = r_sp[AW-1:0];
        w_stk_wdata = r_res;
        w_stk_raddr = r_sp[AW-1:0];
        w_rf_we     = 1'b0;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = w_stk_q;
        w_div_req.divisor  = r_a;

        // Drain the output register on a transfer
        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_cmd;
                    n_a     = i_operand_a;
                    n_b     = i_operand_b;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_OUT;
                n_res   = 32'd0;
                n_err   = ERR_NONE;
                n_halt  = 1'b0;
                n_nip   = r_ip + w_len;
                if (!r_running) begin
                    n_halt = 1'b1;
                    n_nip  = r_ip;
                end else if (w_err != ERR_NONE) begin
                    n_err  = w_err;
                    n_halt = 1'b1;
                    n_nip  = r_ip;
                end else begin
                    case (r_cmd)
                        OP_HALT: begin
                            n_halt = 1'b1;
                        end
                        OP_PUSH: begin
                            w_stk_we    = 1'b1;
                            w_stk_waddr = w_nsp[AW-1:0];
                            w_stk_wdata = r_a;
                            n_res       = r_a;
                            n_sp        = w_nsp[31:0];
                        end
                        OP_SET: begin
                            if (w_a_x == K_IP) begin
                                n_nip = r_b;
                            end else if (w_a_x == K_SP) begin
                                n_sp = r_b;
                            end else begin
                                w_rf_we = 1'b1;
                            end
                        end
                        default: begin
                            // load, pop, add, sub, mul, div wait for read data
                            n_state = S_RD;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = S_OUT;
                case (r_cmd)
                    OP_LOAD: begin
                        w_stk_we    = 1'b1;
                        w_stk_waddr = w_nsp[AW-1:0];
                        w_stk_wdata = w_load_val;
                        n_res       = w_load_val;
                        n_sp        = w_nsp[31:0];
                    end
                    OP_POP: begin
                        n_res = w_stk_q;
                        n_sp  = w_spm1;
                    end
                    OP_MUL: begin
                        n_res   = w_stk_q * r_a;
                        n_state = S_MUL;
                    end
                    OP_DIV: begin
                        w_div_req.start = 1'b1;
                        n_state         = S_DIV;
                    end
                    OP_ADD, OP_SUB: begin
                        // Hold the top, fetch the entry below it
                        n_top       = w_stk_q;
                        w_stk_raddr = w_spm1[AW-1:0];
                        n_state     = S_RD2;
                    end
                    default: begin
                        n_state = S_OUT;
                    end
                endcase
            end
            S_RD2: begin
                n_res       = (r_cmd == OP_ADD) ? (r_top + w_stk_q) : (r_top - w_stk_q);
                w_stk_we    = 1'b1;
                w_stk_waddr = w_spm1[AW-1:0];
                w_stk_wdata = n_res;
                n_sp        = w_spm1;
                n_state     = S_OUT;
            end
            S_MUL: begin
                w_stk_we = 1'b1;
                n_state  = S_OUT;
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    n_res       = w_div_rsp.quotient;
                    w_stk_we    = 1'b1;
                    w_stk_wdata = w_div_rsp.quotient;
                    n_state     = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid = 1'b1;
                    n_ores   = r_res;
                    n_oerr   = r_err;
                    n_ohalt  = r_halt;
                    n_onip   = r_nip;
                    n_ip     = r_nip;
                    if (r_halt) begin
                        n_running = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sp      <= '1;
            r_ip      <= '0;
            r_running <= 1'b1;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sp      <= n_sp;
            r_ip      <= n_ip;
            r_running <= n_running;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_a     <= n_a;
        r_b     <= n_b;
        r_res   <= n_res;
        r_err   <= n_err;
        r_halt  <= n_halt;
        r_nip   <= n_nip;
        r_top   <= n_top;
        r_ores  <= n_ores;
        r_oerr  <= n_oerr;
        r_ohalt <= n_ohalt;
        r_onip  <= n_onip;
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_ovalid;
    assign o_result_value = r_ores;
    assign o_error_code   = r_oerr;
    assign o_halted       = r_ohalt;
    assign o_next_ip      = r_onip;

    `SMX_ASSERT_IMP(a_stopped_reports_halt, i_clk, i_rst_n, r_ovalid && !r_running, r_ohalt)
    `SMX_ASSERT_IMP(a_error_halts, i_clk, i_rst_n, r_ovalid && (r_oerr != ERR_NONE), r_ohalt)
    `SMX_ASSERT_NXT(a_div_exit, i_clk, i_rst_n, r_state == S_DIV, (r_state == S_DIV) || (r_state == S_OUT))

endmodule
